>>> rtl/core/fsts_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed constants of the faded sine tone sample generator.
package fsts_pkg;

  localparam int IDX_W = 20;
  localparam int HZ_W  = 16;
  localparam int VAL_W = 15;
  localparam int MAG_W = 14;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [HZ_W-1:0]  hz_t;
  typedef logic [VAL_W-1:0] sample_t;
  typedef logic [MAG_W-1:0] mag_t;

  localparam hz_t TONE_HZ_RST = 16'd1000;

  // Q30 unity and pi/2 in Q30
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] Q15_RND     = 32'd16384;

  // Horner steps of the sine series; each divides a 32-bit value by 110, 72, 42, 20, 6
  // through an exact reciprocal multiply
  localparam int HORN_STEPS = 5;
  localparam logic [32:0] HORN_MUL [HORN_STEPS] = '{
    33'(((64'd1 << 39) / 64'd110) + 64'd1),
    33'(((64'd1 << 39) / 64'd72)  + 64'd1),
    33'(((64'd1 << 38) / 64'd42)  + 64'd1),
    33'(((64'd1 << 37) / 64'd20)  + 64'd1),
    33'(((64'd1 << 35) / 64'd6)   + 64'd1)
  };
  localparam int HORN_SH [HORN_STEPS] = '{39, 39, 38, 37, 35};

endpackage

>>> rtl/core/faded_sine_tone_sample_top.sv
`timescale 1ns / 1ps
// Faded sine tone sample generator: sample index in, faded PCM tone sample out.
// Takes one sample index per clock while in_tready is high and returns one 15-bit
// signed sample per index, in order. Each index passes a 35-stage pipeline (phase
// reduction, angle scaling, Taylor sine, fade weighting) and an output register;
// throughput is one sample per cycle, held back only by a stalling sink. A two-entry
// output register and skid stage take one word while the sink stalls, after which
// the pipeline holds; in_tready is a registered signal. tone_hz is written
// through the cfg port and must only change while no sample is in flight.
module faded_sine_tone_sample_top
  import fsts_pkg::*;
#(
  parameter int SAMPLE_RATE   = 32000,
  parameter int RAMP_SAMPLES  = 160,
  parameter int TAIL_SAMPLES  = 1600,
  parameter int TOTAL_SAMPLES = 960000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] sample_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] sample_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // [15:0] tone_hz
);

  localparam int PW  = $clog2(SAMPLE_RATE);
  localparam logic [63:0] SR64 = 64'(SAMPLE_RATE);

  localparam logic [63:0] MN64 = (64'd1 << IDX_W) / SR64;
  localparam int QNW = $clog2(MN64 + 64'd2);
  localparam logic [QNW-1:0] MN = QNW'(MN64);

  localparam logic [63:0] MH64 = (64'd1 << HZ_W) / SR64;
  localparam int QHW = $clog2(MH64 + 64'd2);
  localparam logic [QHW-1:0] MH = QHW'(MH64);

  localparam logic [63:0] MP64 = (64'd1 << (2 * PW)) / SR64;
  localparam logic [PW:0] MP = (PW + 1)'(MP64);

  localparam int FCW = 33 - PW;
  localparam logic [63:0] FC64 = (64'd1 << 32) / SR64;
  localparam logic [63:0] FR64 = (64'd1 << 32) % SR64;
  localparam logic [FCW-1:0] FC = FCW'(FC64);
  localparam logic [PW-1:0]  FR = PW'(FR64);

  localparam logic [23:0]     SR24  = 24'(SAMPLE_RATE);
  localparam logic [PW:0]     SR_E  = (PW + 1)'(SAMPLE_RATE);
  localparam logic [2*PW-1:0] SR_W2 = (2 * PW)'(SAMPLE_RATE);

  localparam int BODY      = TOTAL_SAMPLES - TAIL_SAMPLES;
  localparam int BODY_RAMP = BODY - RAMP_SAMPLES;
  localparam int WW        = $clog2(RAMP_SAMPLES + 1);

  localparam int NW = 17 + WW;
  localparam int LR = $clog2(8 * RAMP_SAMPLES);
  localparam logic [63:0] DR64 = 64'(8 * RAMP_SAMPLES);
  localparam logic [63:0] MR64 = ((64'd1 << (NW + LR)) / DR64) + 64'd1;
  localparam logic [NW:0] MR = (NW + 1)'(MR64);

  localparam int NST = 35;

  logic adv;
  logic [NST:1] vld_r;

  hz_t tone_hz_r;

  // stage 1..3: index and tone reduced modulo the sample rate
  idx_t                 n_in;
  int                   n_int;
  logic [IDX_W+QNW-1:0] qn_prod;
  logic [HZ_W+QHW-1:0]  qh_prod;
  logic                 z1_nxt;
  logic [WW-1:0]        w1_nxt;
  logic [QNW-1:0]       qn1_r;
  logic [QHW-1:0]       qh1_r;
  idx_t                 n1_r;
  logic [23:0]          rn_diff, rh_diff;
  logic [PW:0]          rn2_r, rh2_r;
  logic [PW:0]          rn3_sub, rh3_sub;
  logic [PW-1:0]        rn3_r, rh3_r;

  // stage 4..7: phase = (rn * rh) mod rate
  logic [2*PW-1:0] pr4_r, pr5_r;
  logic [3*PW:0]   qp_prod;
  logic [PW-1:0]   qp5_r;
  logic [2*PW-1:0] pe_diff;
  logic [PW:0]     pe6_r, pe7_sub;
  logic [PW-1:0]   p7_r;

  // stage 8..11: angle fraction floor(p * 2^32 / rate)
  logic [PW+FCW-1:0] a_prod;
  logic [31:0]       a8_r, a9_r;
  logic [2*PW-1:0]   b8_r, b9_r;
  logic [3*PW:0]     qb_prod;
  logic [PW-1:0]     qb9_r;
  logic [2*PW-1:0]   be_diff;
  logic [31:0]       sum10_r;
  logic [PW:0]       be10_r;
  logic [31:0]       f11_r;

  // stage 12..14: quadrant fold and pi/2 scaling
  logic [30:0] x12_r;
  logic [61:0] y_prod, y2_prod;
  logic [30:0] y13_r;

  // stage 15..29: Horner steps, three stages each
  logic [30:0] t_in    [HORN_STEPS];
  logic [62:0] hv_prod [HORN_STEPS];
  logic [64:0] hq_prod [HORN_STEPS];
  logic [31:0] hv_r    [HORN_STEPS];
  logic [30:0] hq_r    [HORN_STEPS];
  logic [30:0] ht_r    [HORN_STEPS];

  // stage 30..35: Q15 rounding, fade and sign
  logic [61:0]        yt_prod;
  logic [31:0]        yt30_r, yt_rnd;
  logic [15:0]        s31_r;
  logic [15+WW:0]     sw32_r;
  logic [NW-1:0]      num33_r;
  logic [2*NW:0]      m_prod;
  mag_t               mag34_r;
  sample_t            mag_ext;
  sample_t            val35_r;

  // carried fields
  logic [WW-1:0] w_r   [1:31];
  logic          z_r   [1:34];
  logic          neg_r [12:34];
  logic [30:0]   y_r   [13:29];
  logic [31:0]   y2_r  [14:26];

  // output register and skid
  logic    out_vld_r, skid_vld_r, push;
  sample_t out_data_r, skid_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_hz_r <= TONE_HZ_RST;
    end else if (cfg_valid) begin
      tone_hz_r <= cfg_data;
    end
  end

  assign in_tready = !skid_vld_r;
  assign adv       = in_tready;

  // stage 1
  assign n_in    = in_tdata[IDX_W-1:0];
  assign n_int   = int'({12'd0, n_in});
  assign qn_prod = (IDX_W + QNW)'(n_in) * (IDX_W + QNW)'(MN);
  assign qh_prod = (HZ_W + QHW)'(tone_hz_r) * (HZ_W + QHW)'(MH);
  assign z1_nxt  = (n_int >= BODY);

  always_comb begin
    priority if (n_int < RAMP_SAMPLES) begin
      w1_nxt = WW'(n_in);
    end else if (n_int > BODY_RAMP) begin
      w1_nxt = WW'(BODY - n_int);
    end else begin
      w1_nxt = WW'(RAMP_SAMPLES);
    end
  end

  // stage 2, 3
  assign rn_diff = {4'd0, n1_r} - 24'(qn1_r) * SR24;
  assign rh_diff = {8'd0, tone_hz_r} - 24'(qh1_r) * SR24;
  assign rn3_sub = (rn2_r >= SR_E) ? (rn2_r - SR_E) : rn2_r;
  assign rh3_sub = (rh2_r >= SR_E) ? (rh2_r - SR_E) : rh2_r;

  // stage 5..7
  assign qp_prod = (3 * PW + 1)'(pr4_r) * (3 * PW + 1)'(MP);
  assign pe_diff = pr5_r - (2 * PW)'(qp5_r) * SR_W2;
  assign pe7_sub = (pe6_r >= SR_E) ? (pe6_r - SR_E) : pe6_r;

  // stage 8..10
  assign a_prod  = (PW + FCW)'(p7_r) * (PW + FCW)'(FC);
  assign qb_prod = (3 * PW + 1)'(b8_r) * (3 * PW + 1)'(MP);
  assign be_diff = b9_r - (2 * PW)'(qb9_r) * SR_W2;

  // stage 13, 14
  assign y_prod  = 62'(x12_r) * 62'(HALF_PI_Q30);
  assign y2_prod = 62'(y13_r) * 62'(y13_r);

  always_comb begin
    t_in[0] = Q30_ONE;
    for (int k = 1; k < HORN_STEPS; k++) begin
      t_in[k] = ht_r[k-1];
    end
    for (int k = 0; k < HORN_STEPS; k++) begin
      hv_prod[k] = 63'(y2_r[14+3*k]) * 63'(t_in[k]);
      hq_prod[k] = 65'(hv_r[k]) * 65'(HORN_MUL[k]);
    end
  end

  // stage 30..35
  assign yt_prod = 62'(y_r[29]) * 62'(ht_r[HORN_STEPS-1]);
  assign yt_rnd  = yt30_r + Q15_RND;
  assign m_prod  = (2 * NW + 1)'(num33_r) * (2 * NW + 1)'(MR);
  assign mag_ext = VAL_W'(mag34_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-1:1], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r    <= n_in;
      qn1_r   <= qn_prod[IDX_W+QNW-1:IDX_W];
      qh1_r   <= qh_prod[HZ_W+QHW-1:HZ_W];
      rn2_r   <= rn_diff[PW:0];
      rh2_r   <= rh_diff[PW:0];
      rn3_r   <= rn3_sub[PW-1:0];
      rh3_r   <= rh3_sub[PW-1:0];
      pr4_r   <= (2 * PW)'(rn3_r) * (2 * PW)'(rh3_r);
      pr5_r   <= pr4_r;
      qp5_r   <= qp_prod[3*PW-1:2*PW];
      pe6_r   <= pe_diff[PW:0];
      p7_r    <= pe7_sub[PW-1:0];
      a8_r    <= a_prod[31:0];
      b8_r    <= (2 * PW)'(p7_r) * (2 * PW)'(FR);
      a9_r    <= a8_r;
      b9_r    <= b8_r;
      qb9_r   <= qb_prod[3*PW-1:2*PW];
      sum10_r <= a9_r + 32'(qb9_r);
      be10_r  <= be_diff[PW:0];
      f11_r   <= sum10_r + ((be10_r >= SR_E) ? 32'd1 : 32'd0);
      x12_r   <= f11_r[30] ? (Q30_ONE - {1'b0, f11_r[29:0]}) : {1'b0, f11_r[29:0]};
      y13_r   <= y_prod[60:30];
      for (int k = 0; k < HORN_STEPS; k++) begin
        hv_r[k] <= hv_prod[k][61:30];
        hq_r[k] <= 31'(hq_prod[k] >> HORN_SH[k]);
        ht_r[k] <= Q30_ONE - hq_r[k];
      end
      yt30_r  <= yt_prod[61:30];
      s31_r   <= yt_rnd[30:15];
      sw32_r  <= (16 + WW)'(s31_r) * (16 + WW)'(w_r[31]);
      num33_r <= {sw32_r, 1'b0} + NW'(4 * RAMP_SAMPLES);
      mag34_r <= MAG_W'(m_prod >> (NW + LR));
      if (z_r[34]) begin
        val35_r <= '0;
      end else if (neg_r[34]) begin
        val35_r <= sample_t'(0) - mag_ext;
      end else begin
        val35_r <= mag_ext;
      end

      w_r[1] <= w1_nxt;
      for (int i = 2; i <= 31; i++) begin
        w_r[i] <= w_r[i-1];
      end
      z_r[1] <= z1_nxt;
      for (int i = 2; i <= 34; i++) begin
        z_r[i] <= z_r[i-1];
      end
      neg_r[12] <= f11_r[31];
      for (int i = 13; i <= 34; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
      y_r[13] <= y_prod[60:30];
      for (int i = 14; i <= 29; i++) begin
        y_r[i] <= y_r[i-1];
      end
      y2_r[14] <= y2_prod[61:30];
      for (int i = 15; i <= 26; i++) begin
        y2_r[i] <= y2_r[i-1];
      end
    end
  end

  // output word register with one skid entry
  assign push = adv && vld_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_tready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        out_data_r <= skid_data_r;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= push;
        if (push) begin
          out_data_r <= val35_r;
        end
      end
    end else if (push) begin
      skid_vld_r  <= 1'b1;
      skid_data_r <= val35_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_data_r};

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held with empty output register");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (($signed(out_data_r) <= 15'sd8192) &&
                   ($signed(out_data_r) >= -15'sd8192)))
    else $error("output sample beyond peak");

  a_tail_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NST] && $past(adv) && $past(z_r[34])) |-> (val35_r == '0))
    else $error("tail sample not silent");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the faded sine tone sample generator over its stream ports.
module testbench;
  import fsts_pkg::*;

  localparam longint unsigned RATE   = 32000;
  localparam longint unsigned RAMP   = 160;
  localparam longint unsigned TAIL   = 1600;
  localparam longint unsigned TOTAL  = 960000;
  localparam longint unsigned BODY   = TOTAL - TAIL;
  localparam longint unsigned UNITY  = 64'd1 << 30;
  localparam longint unsigned QPI_Q30 = 64'd1686629713;
  localparam int PHASES    = 8;
  localparam int PER_PHASE = 200;
  localparam int HOLD_LEN  = 400;
  localparam int LIMIT     = 400000;

  class tone_scoreboard;
    sample_t     pending_q[$];
    hz_t         tone;
    int unsigned errors;
    int unsigned matched;

    function new();
      tone    = TONE_HZ_RST;
      errors  = 0;
      matched = 0;
    endfunction

    function void set_tone(hz_t hz);
      tone = hz;
    endfunction

    // sine in Q15 from the Taylor series by Horner, Q30 throughout
    function automatic longint unsigned sine_q15(longint unsigned x);
      longint unsigned y, y2, t;
      y  = (x * QPI_Q30) >> 30;
      y2 = (y * y) >> 30;
      t  = UNITY;
      t  = UNITY - ((y2 * t) >> 30) / 110;
      t  = UNITY - ((y2 * t) >> 30) / 72;
      t  = UNITY - ((y2 * t) >> 30) / 42;
      t  = UNITY - ((y2 * t) >> 30) / 20;
      t  = UNITY - ((y2 * t) >> 30) / 6;
      return (((y * t) >> 30) + 16384) >> 15;
    endfunction

    function automatic sample_t faded_sample(idx_t idx);
      longint unsigned n, hz, w, p, f, r, x, s, mag;
      logic [1:0] quad;
      n  = idx;
      hz = tone;
      if (n >= BODY) return '0;
      if (n < RAMP) w = n;
      else if (n > BODY - RAMP) w = BODY - n;
      else w = RAMP;
      p    = ((n % RATE) * hz) % RATE;
      f    = (p << 32) / RATE;
      quad = 2'(f >> 30);
      r    = f & (UNITY - 1);
      x    = quad[0] ? UNITY - r : r;
      s    = sine_q15(x);
      mag  = (s * w * 2 + 4 * RAMP) / (8 * RAMP);
      return quad[1] ? sample_t'(-mag) : sample_t'(mag);
    endfunction

    function void note_index(idx_t n);
      pending_q.push_back(faded_sample(n));
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (pending_q.size() == 0) begin
        $error("sample_value: none expected, got %0d", $signed(got));
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $error("sample_value: expected %0d, got %0d", $signed(want), $signed(got));
        errors++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  tone_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_req      = 0;
  int stall_ack      = 0;
  int hold_left      = 0;
  int cycle_cnt      = 0;

  idx_t corner_idx [20] = '{
    20'd0, 20'd1, 20'd8, 20'd159, 20'd160, 20'd161, 20'd8008, 20'd8016, 20'd8024,
    20'd12345, idx_t'(BODY - RAMP - 1), idx_t'(BODY - RAMP), idx_t'(BODY - RAMP + 1),
    idx_t'(BODY - 1), idx_t'(BODY), 20'd959999, 20'd960000, 20'h55555, 20'hAAAAA, 20'hFFFFF
  };

  faded_sine_tone_sample_top #(
    .SAMPLE_RATE   (32000),
    .RAMP_SAMPLES  (160),
    .TAIL_SAMPLES  (1600),
    .TOTAL_SAMPLES (960000)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("[faded_sine_tone_sample_top] ERROR");
      $finish;
    end
  end

  // sink: checks each word, random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sample(out_tdata[VAL_W-1:0]);
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_ack != stall_req) begin
      stall_ack  <= stall_req;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic idx_t pick_index();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1:    return idx_t'($urandom_range(RAMP + 40));
      2, 3:    return idx_t'($urandom_range(BODY + 40, BODY - RAMP - 40));
      4:       return idx_t'($urandom_range(20'hFFFFF, BODY));
      default: return idx_t'($urandom());
    endcase
  endfunction

  task automatic send_index(input idx_t n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, n};
    do @(posedge clk); while (!in_tready);
    sb.note_index(n);
  endtask

  task automatic write_tone(input hz_t hz);
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_tone(hz);
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    hz_t hz;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // corners at the reset tone
    foreach (corner_idx[i]) send_index(corner_idx[i]);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       hz = 16'hFFFF;
        1:       hz = 16'd0;
        2:       hz = 16'd1;
        3:       hz = 16'd32000;
        4:       hz = 16'd16000;
        5:       hz = 16'd31999;
        default: hz = hz_t'($urandom());
      endcase
      write_tone(hz);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1:       begin send_idle_pct = 78; recv_stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct <= 78; end
        default: begin send_idle_pct = 20; recv_stall_pct <= 20; end
      endcase
      if (ph == 0) stall_req <= stall_req + 1;
      repeat (PER_PHASE) send_index(pick_index());
      drain();
    end

    repeat (40) @(posedge clk);
    foreach (sb.pending_q[i]) begin
      $error("sample_value: expected %0d, never arrived", $signed(sb.pending_q[i]));
      sb.errors++;
    end
    $display("Checked %0d samples over %0d tone settings: fade ramps, silent tail, wrapped",
             sb.matched, PHASES + 1);
    $display("indices, zero and full-scale tones, and a long sink hold-off.");
    if (sb.errors == 0) begin
      $display("[faded_sine_tone_sample_top] OK");
    end else begin
      $display("[faded_sine_tone_sample_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fsts_pkg.sv
rtl/core/faded_sine_tone_sample_top.sv
tb/sv/testbench.sv
